// ===== hdl/m3ua_pkg.sv =====
// shared types and constants for the application-server state machine
package m3ua_pkg;

  localparam int NUM_ASPS    = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 20;
  localparam int AIW  = (NUM_ASPS > 1) ? $clog2(NUM_ASPS) : 1;
  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW  = $clog2(2 * QUEUE_DEPTH);
  localparam int RCW  = $clog2(MAX_RESULTS + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_OVERRIDE = 3'd0;
  localparam logic [2:0] CFG_RECOVERY = 3'd1;
  localparam logic [2:0] CFG_ROLE     = 3'd2;
  localparam logic [2:0] CFG_IPA      = 3'd3;
  localparam logic [2:0] CFG_SCCP     = 3'd4;

  // local roles
  localparam logic [1:0] ROLE_ASP = 2'd0;
  localparam logic [1:0] ROLE_SG  = 2'd1;

  // as state and per-asp state share one encoding
  typedef enum logic [1:0] {
    ST_DOWN, ST_INACTIVE, ST_ACTIVE, ST_PENDING
  } as_st_t;

  typedef enum logic [2:0] {
    OP_INACT, OP_DOWN, OP_ACT, OP_XFER, OP_TICK, OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    K_NONE, K_NOTIFY_ALL, K_NOTIFY_ONE, K_DEMOTE, K_FORWARD,
    K_DROP, K_AVAIL, K_DUNA, K_QUEUED
  } kind_t;

  typedef enum logic [1:0] {
    SQ_IDLE, SQ_UPD, SQ_EXEC, SQ_RUN
  } seq_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  asp;
    logic        is_sg;
    logic        ntfy;
    logic [15:0] tag;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  asp;
    logic [15:0] tag;
    as_st_t      st;
    logic        avail;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        override_mode;
    logic [15:0] recovery_ticks;
    logic [1:0]  local_role;
    logic        peer_ipa;
    logic        sccp_present;
  } cfg_t;

endpackage

// ===== hdl/m3ua_ram.sv =====
// generic single-write, single-read ram with registered read
module m3ua_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                       wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                       rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/m3ua_front.sv =====
// front end: input queue and action classification
module m3ua_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           in_action,
  input  logic [3:0]           in_asp_index,
  input  logic                 in_asp_is_sg,
  input  logic                 in_notify_requested,
  input  logic [15:0]          in_msg_tag,
  output logic                 item_valid,
  input  logic                 item_pop,
  output m3ua_pkg::item_t      item
);

  m3ua_pkg::item_t q_r [2];
  m3ua_pkg::item_t cls;
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  // classify the action code
  always_comb begin
    cls.op    = (in_action <= 3'd4) ? m3ua_pkg::op_t'(in_action) : m3ua_pkg::OP_NONE;
    cls.asp   = in_asp_index;
    cls.is_sg = in_asp_is_sg;
    cls.ntfy  = in_notify_requested;
    cls.tag   = in_msg_tag;
  end

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hdl/m3ua_outq.sv =====
// result queue between the sequencer and the result port
module m3ua_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  m3ua_pkg::res_t  wdata,
  output logic            oq_full,
  output logic            empty,
  input  logic            pop,
  output m3ua_pkg::res_t  head
);

  m3ua_pkg::res_t q_r [4];
  logic [1:0]     wp_r, rp_r;
  logic [2:0]     cnt_r;
  logic           do_pop;

  assign oq_full = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign head    = q_r[rp_r];
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= wdata;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr)     wp_r <= wp_r + 2'd1;
      if (do_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, do_pop};
    end
  end

endmodule

// ===== hdl/m3ua_back.sv =====
// back end: as state, asp table, recovery timer, pending queue, result sequencer
module m3ua_back (
  input  logic             clk,
  input  logic             rst_n,
  input  m3ua_pkg::cfg_t   cfg,
  input  logic             item_valid,
  output logic             item_pop,
  input  m3ua_pkg::item_t  item,
  output logic             oq_wr,
  output m3ua_pkg::res_t   oq_data,
  input  logic             oq_full
);

  m3ua_pkg::seq_t   sq_r, sq_nxt;
  m3ua_pkg::item_t  it_r, it_nxt;
  m3ua_pkg::as_st_t tbl_r [m3ua_pkg::NUM_ASPS];
  m3ua_pkg::as_st_t tbl_nxt [m3ua_pkg::NUM_ASPS];
  m3ua_pkg::as_st_t as_r, as_nxt, chg_st_r, chg_st_nxt;
  m3ua_pkg::kind_t  tag_kind_r, tag_kind_nxt;
  m3ua_pkg::res_t   hold_r, hold_nxt, emit_res;
  logic [15:0]                  rec_r, rec_nxt;
  logic [m3ua_pkg::QAW-1:0]     head_r, head_nxt, tail;
  logic [m3ua_pkg::QSW-1:0]     tsum;
  logic [m3ua_pkg::QCW-1:0]     qcnt_r, qcnt_nxt;
  logic [m3ua_pkg::AIW-1:0]     d_r, d_nxt;
  logic [m3ua_pkg::RCW-1:0]     n_r, n_nxt;
  logic pre_r, pre_nxt, chg_r, chg_nxt, av_r, av_nxt, av_val_r, av_val_nxt;
  logic duna_r, duna_nxt, one_r, one_nxt, tag_r, tag_nxt, post_r, post_nxt;
  logic dem_r, dem_nxt, rd_pend_r, rd_pend_nxt, hold_v_r, hold_v_nxt;
  logic emit_req, can_emit, capped, emit_ok, ram_we, up, dn, tgt;
  logic [m3ua_pkg::NUM_ASPS-1:0] self_m, act_v, nd_v;
  logic oth_act, oth_nd, any_nd;
  logic [15:0] ram_rdata;

  // pending transfer store
  m3ua_ram #(.W(16), .D(m3ua_pkg::QUEUE_DEPTH)) u_pq (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (it_r.tag),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // queue tail position
  always_comb begin
    tsum = m3ua_pkg::QSW'(head_r) + m3ua_pkg::QSW'(qcnt_r);
    if (tsum >= m3ua_pkg::QSW'(m3ua_pkg::QUEUE_DEPTH)) begin
      tsum = tsum - m3ua_pkg::QSW'(m3ua_pkg::QUEUE_DEPTH);
    end
    tail = m3ua_pkg::QAW'(tsum);
  end

  // table summaries
  always_comb begin
    for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) begin
      self_m[i] = (int'(it_r.asp) == i);
      act_v[i]  = (tbl_r[i] == m3ua_pkg::ST_ACTIVE);
      nd_v[i]   = (tbl_r[i] != m3ua_pkg::ST_DOWN);
    end
    oth_act = |(act_v & ~self_m);
    oth_nd  = |(nd_v & ~self_m);
    any_nd  = |nd_v;
  end

  assign capped   = (n_r == m3ua_pkg::RCW'(m3ua_pkg::MAX_RESULTS));
  assign can_emit = !hold_v_r || !oq_full;
  assign emit_ok  = can_emit || capped;
  assign tgt      = (int'(d_r) != int'(it_r.asp)) && (tbl_r[d_r] == m3ua_pkg::ST_ACTIVE);
  assign up       = (as_r != m3ua_pkg::ST_ACTIVE) && (chg_st_r == m3ua_pkg::ST_ACTIVE);
  assign dn       = (as_r == m3ua_pkg::ST_ACTIVE) && (chg_st_r != m3ua_pkg::ST_ACTIVE);

  // sequencer next state
  always_comb begin
    sq_nxt = sq_r;       it_nxt = it_r;       as_nxt = as_r;
    chg_st_nxt = chg_st_r; tag_kind_nxt = tag_kind_r;
    rec_nxt = rec_r;     head_nxt = head_r;   qcnt_nxt = qcnt_r;
    d_nxt = d_r;         n_nxt = n_r;         hold_nxt = hold_r; hold_v_nxt = hold_v_r;
    pre_nxt = pre_r;     chg_nxt = chg_r;     av_nxt = av_r;     av_val_nxt = av_val_r;
    duna_nxt = duna_r;   one_nxt = one_r;     tag_nxt = tag_r;   post_nxt = post_r;
    dem_nxt = dem_r;     rd_pend_nxt = rd_pend_r;
    for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) tbl_nxt[i] = tbl_r[i];
    item_pop = 1'b0; ram_we = 1'b0; oq_wr = 1'b0; oq_data = hold_r;
    emit_req = 1'b0;
    emit_res = '{kind: m3ua_pkg::K_NONE, asp: 4'd0, tag: 16'd0, st: as_r,
                 avail: 1'b0, last: 1'b0};
    case (sq_r)
      m3ua_pkg::SQ_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          it_nxt   = item;
          n_nxt    = '0;
          sq_nxt   = m3ua_pkg::SQ_UPD;
        end
      end
      // asp table update comes first
      m3ua_pkg::SQ_UPD: begin
        for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) begin
          if (self_m[i]) begin
            case (it_r.op)
              m3ua_pkg::OP_INACT: tbl_nxt[i] = m3ua_pkg::ST_INACTIVE;
              m3ua_pkg::OP_DOWN:  tbl_nxt[i] = m3ua_pkg::ST_DOWN;
              m3ua_pkg::OP_ACT:   tbl_nxt[i] = m3ua_pkg::ST_ACTIVE;
              default: ;
            endcase
          end
        end
        sq_nxt = m3ua_pkg::SQ_EXEC;
      end
      // decide what this item does
      m3ua_pkg::SQ_EXEC: begin
        d_nxt  = '0;
        sq_nxt = m3ua_pkg::SQ_RUN;
        case (as_r)
          m3ua_pkg::ST_DOWN: begin
            if (it_r.op == m3ua_pkg::OP_INACT) begin
              chg_nxt = 1'b1; chg_st_nxt = m3ua_pkg::ST_INACTIVE;
            end else if (it_r.op == m3ua_pkg::OP_XFER) begin
              tag_nxt = 1'b1; tag_kind_nxt = m3ua_pkg::K_DROP;
            end
          end
          m3ua_pkg::ST_INACTIVE: begin
            case (it_r.op)
              m3ua_pkg::OP_DOWN: if (!oth_nd) begin
                chg_nxt = 1'b1; chg_st_nxt = m3ua_pkg::ST_DOWN;
              end
              m3ua_pkg::OP_ACT: begin
                chg_nxt = 1'b1; chg_st_nxt = m3ua_pkg::ST_ACTIVE;
                duna_nxt = it_r.is_sg;
              end
              m3ua_pkg::OP_INACT: one_nxt = it_r.ntfy;
              m3ua_pkg::OP_XFER: begin
                tag_nxt = 1'b1; tag_kind_nxt = m3ua_pkg::K_DROP;
              end
              default: ;
            endcase
          end
          m3ua_pkg::ST_ACTIVE: begin
            case (it_r.op)
              m3ua_pkg::OP_DOWN, m3ua_pkg::OP_INACT: begin
                if (!oth_act) begin
                  chg_nxt = 1'b1; chg_st_nxt = m3ua_pkg::ST_PENDING;
                  rec_nxt = (cfg.recovery_ticks != 16'd0) ? cfg.recovery_ticks : 16'd1;
                end else if (it_r.op == m3ua_pkg::OP_INACT) begin
                  one_nxt = it_r.ntfy;
                end
              end
              m3ua_pkg::OP_ACT: dem_nxt = cfg.override_mode;
              m3ua_pkg::OP_XFER: begin
                tag_nxt = 1'b1; tag_kind_nxt = m3ua_pkg::K_FORWARD;
              end
              default: ;
            endcase
          end
          default: begin
            case (it_r.op)
              m3ua_pkg::OP_ACT: begin
                rec_nxt = 16'd0;
                chg_nxt = 1'b1; chg_st_nxt = m3ua_pkg::ST_ACTIVE;
                duna_nxt = it_r.is_sg;
                post_nxt = 1'b1;
              end
              m3ua_pkg::OP_INACT: one_nxt = it_r.ntfy;
              m3ua_pkg::OP_XFER: begin
                tag_nxt = 1'b1;
                if (qcnt_r < m3ua_pkg::QCW'(m3ua_pkg::QUEUE_DEPTH)) begin
                  ram_we = 1'b1;
                  qcnt_nxt = qcnt_r + 1'b1;
                  tag_kind_nxt = m3ua_pkg::K_QUEUED;
                end else begin
                  tag_kind_nxt = m3ua_pkg::K_DROP;
                end
              end
              m3ua_pkg::OP_TICK: if (rec_r != 16'd0) begin
                rec_nxt = rec_r - 16'd1;
                if (rec_r == 16'd1) begin
                  pre_nxt = 1'b1;
                  chg_nxt = 1'b1;
                  chg_st_nxt = any_nd ? m3ua_pkg::ST_INACTIVE : m3ua_pkg::ST_DOWN;
                end
              end
              default: ;
            endcase
          end
        endcase
      end
      // one step of the result sequence per cycle while the result queue has room
      m3ua_pkg::SQ_RUN: begin
        // expiry drops lead; activation forwards follow the duna request
        if (pre_r || (post_r && !chg_r && !av_r && !duna_r)) begin
          if (qcnt_r == '0) begin
            if (pre_r) pre_nxt = 1'b0;
            else       post_nxt = 1'b0;
          end else if (!rd_pend_r) begin
            rd_pend_nxt = 1'b1;
          end else begin
            emit_req = 1'b1;
            emit_res.kind = pre_r ? m3ua_pkg::K_DROP : m3ua_pkg::K_FORWARD;
            emit_res.tag  = ram_rdata;
            if (emit_ok) begin
              rd_pend_nxt = 1'b0;
              qcnt_nxt = qcnt_r - 1'b1;
              head_nxt = (head_r == m3ua_pkg::QAW'(m3ua_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : head_r + 1'b1;
            end
          end
        end else if (chg_r) begin
          emit_req = (chg_st_r != m3ua_pkg::ST_DOWN) && !cfg.peer_ipa;
          emit_res.kind = m3ua_pkg::K_NOTIFY_ALL;
          emit_res.st   = chg_st_r;
          if (!emit_req || emit_ok) begin
            chg_nxt = 1'b0;
            as_nxt  = chg_st_r;
            av_nxt  = (chg_st_r != m3ua_pkg::ST_DOWN) && (up || dn) &&
                      (((cfg.local_role == m3ua_pkg::ROLE_ASP) && cfg.sccp_present) ||
                       (cfg.local_role == m3ua_pkg::ROLE_SG));
            av_val_nxt = up;
          end
        end else if (av_r) begin
          emit_req = 1'b1;
          emit_res.kind  = m3ua_pkg::K_AVAIL;
          emit_res.avail = av_val_r;
          if (emit_ok) av_nxt = 1'b0;
        end else if (duna_r) begin
          emit_req = 1'b1;
          emit_res.kind = m3ua_pkg::K_DUNA;
          emit_res.asp  = it_r.asp;
          if (emit_ok) duna_nxt = 1'b0;
        end else if (one_r) begin
          emit_req = 1'b1;
          emit_res.kind = m3ua_pkg::K_NOTIFY_ONE;
          emit_res.asp  = it_r.asp;
          if (emit_ok) one_nxt = 1'b0;
        end else if (tag_r) begin
          emit_req = 1'b1;
          emit_res.kind = tag_kind_r;
          emit_res.tag  = it_r.tag;
          if (emit_ok) tag_nxt = 1'b0;
        end else if (dem_r) begin
          emit_req = tgt;
          emit_res.kind = m3ua_pkg::K_DEMOTE;
          emit_res.asp  = 4'(d_r);
          if (!emit_req || emit_ok) begin
            if (tgt) tbl_nxt[d_r] = m3ua_pkg::ST_INACTIVE;
            if (d_r == m3ua_pkg::AIW'(m3ua_pkg::NUM_ASPS - 1)) dem_nxt = 1'b0;
            else d_nxt = d_r + 1'b1;
          end
        end else begin
          // flush the held result with the last mark
          if (!hold_v_r) begin
            sq_nxt = m3ua_pkg::SQ_IDLE;
          end else if (!oq_full) begin
            oq_wr = 1'b1;
            oq_data = hold_r;
            oq_data.last = 1'b1;
            hold_v_nxt = 1'b0;
            sq_nxt = m3ua_pkg::SQ_IDLE;
          end
        end
      end
      default: sq_nxt = m3ua_pkg::SQ_IDLE;
    endcase
    // one result is held back so the final one can be marked
    if (emit_req && can_emit && !capped) begin
      if (hold_v_r) begin
        oq_wr = 1'b1;
        oq_data = hold_r;
      end
      hold_nxt   = emit_res;
      hold_v_nxt = 1'b1;
      n_nxt      = n_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    it_r       <= it_nxt;
    hold_r     <= hold_nxt;
    chg_st_r   <= chg_st_nxt;
    tag_kind_r <= tag_kind_nxt;
    av_val_r   <= av_val_nxt;
    d_r        <= d_nxt;
    n_r        <= n_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= m3ua_pkg::SQ_IDLE;
      as_r <= m3ua_pkg::ST_DOWN;
      for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) tbl_r[i] <= m3ua_pkg::ST_DOWN;
      rec_r <= 16'd0; head_r <= '0; qcnt_r <= '0;
      pre_r <= 1'b0; chg_r <= 1'b0; av_r <= 1'b0; duna_r <= 1'b0; one_r <= 1'b0;
      tag_r <= 1'b0; post_r <= 1'b0; dem_r <= 1'b0; rd_pend_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      sq_r <= sq_nxt;
      as_r <= as_nxt;
      for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) tbl_r[i] <= tbl_nxt[i];
      rec_r <= rec_nxt; head_r <= head_nxt; qcnt_r <= qcnt_nxt;
      pre_r <= pre_nxt; chg_r <= chg_nxt; av_r <= av_nxt; duna_r <= duna_nxt;
      one_r <= one_nxt; tag_r <= tag_nxt; post_r <= post_nxt; dem_r <= dem_nxt;
      rd_pend_r <= rd_pend_nxt; hold_v_r <= hold_v_nxt;
    end
  end

endmodule

// ===== hdl/m3ua_as_state_machine_top.sv =====
// top level of the application-server state machine
//
//   channel   direction  handshake        transfer when
//   input     in         push / full      push && !full
//   result    out        pop / empty      pop && !empty
//   config    in         cfg_we           cfg_we
//
// an item is taken in idle, then passes the update and decide states; the
// run state emits its results. each queued tag flushed on recovery or
// activation is read through the pending store port; an override demotion
// scan walks the asp table. a full result queue stalls the sequencer.
// reset is synchronous and leaves the as down, all asps down, queue empty.
// a two-entry input queue and a four-entry result queue let each side stall.
module m3ua_as_state_machine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_asp_index,
  input  logic        in_asp_is_sg,
  input  logic        in_notify_requested,
  input  logic [15:0] in_msg_tag,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_result_kind,
  output logic [3:0]  out_asp_index_res,
  output logic [15:0] out_msg_tag_res,
  output logic [1:0]  out_as_state,
  output logic        out_available,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  m3ua_pkg::cfg_t  cfg_r;
  m3ua_pkg::item_t item;
  m3ua_pkg::res_t  oq_data, oq_head;
  logic            item_valid, item_pop, oq_wr, oq_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.override_mode  <= 1'b1;
      cfg_r.recovery_ticks <= 16'd2000;
      cfg_r.local_role     <= 2'd0;
      cfg_r.peer_ipa       <= 1'b0;
      cfg_r.sccp_present   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        m3ua_pkg::CFG_OVERRIDE: cfg_r.override_mode  <= cfg_data[0];
        m3ua_pkg::CFG_RECOVERY: cfg_r.recovery_ticks <= cfg_data;
        m3ua_pkg::CFG_ROLE:     cfg_r.local_role     <= cfg_data[1:0];
        m3ua_pkg::CFG_IPA:      cfg_r.peer_ipa       <= cfg_data[0];
        m3ua_pkg::CFG_SCCP:     cfg_r.sccp_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  m3ua_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_action           (in_action),
    .in_asp_index        (in_asp_index),
    .in_asp_is_sg        (in_asp_is_sg),
    .in_notify_requested (in_notify_requested),
    .in_msg_tag          (in_msg_tag),
    .item_valid          (item_valid),
    .item_pop            (item_pop),
    .item                (item)
  );

  m3ua_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .oq_wr      (oq_wr),
    .oq_data    (oq_data),
    .oq_full    (oq_full)
  );

  m3ua_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (oq_wr),
    .wdata   (oq_data),
    .oq_full (oq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (oq_head)
  );

  // result ports
  assign out_result_kind   = 4'(oq_head.kind);
  assign out_asp_index_res = oq_head.asp;
  assign out_msg_tag_res   = oq_head.tag;
  assign out_as_state      = 2'(oq_head.st);
  assign out_available     = oq_head.avail;
  assign out_last          = oq_head.last;

`ifndef NO_ASSERTIONS
  // the sequencer never writes a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_wr |-> !oq_full) else $error("result queue overflow");

  // the sequencer only takes an item that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid) else $error("item taken from empty queue");

  // queued tags only come out while pending
  a_queued_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == 4'(m3ua_pkg::K_QUEUED))
      |-> out_as_state == 2'(m3ua_pkg::ST_PENDING))
    else $error("queued result outside pending");

  // forwarded tags only come out while active
  a_fwd_active: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == 4'(m3ua_pkg::K_FORWARD))
      |-> out_as_state == 2'(m3ua_pkg::ST_ACTIVE))
    else $error("forward result outside active");
`endif

endmodule

// ===== sim/tb_m3ua_as_state_machine_top.sv =====
// testbench for the application-server state machine: predictor, driver and monitor
`timescale 1ns / 100ps

module tb_m3ua_as_state_machine_top;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  asp;
    logic        is_sg;
    logic        ntfy;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  asp;
    logic [15:0] tag;
    logic [1:0]  st;
    logic        avail;
    logic        last;
  } note_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  in_action = '0;
  logic [3:0]  in_asp_index = '0;
  logic        in_asp_is_sg = 1'b0;
  logic        in_notify_requested = 1'b0;
  logic [15:0] in_msg_tag = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  out_result_kind;
  logic [3:0]  out_asp_index_res;
  logic [15:0] out_msg_tag_res;
  logic [1:0]  out_as_state;
  logic        out_available;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  m3ua_as_state_machine_top dut (.*);

  always #5 clk = ~clk;

  // predictor state and configuration copy
  logic        p_override;
  logic [15:0] p_ticks;
  logic [1:0]  p_role;
  logic        p_ipa;
  logic        p_sccp;
  logic [1:0]  p_as;
  logic [1:0]  p_asp [m3ua_pkg::NUM_ASPS];
  logic [15:0] p_timer;
  logic [15:0] p_pend [$];

  req_t  pending_reqs [$];
  note_t expected_notes [$];
  note_t step_notes [$];
  int    mismatches = 0;
  bit    quiet = 0;
  bit    hold_in = 0;

  function automatic void note(input int k, input int a, input int t, input int av);
    note_t n;
    if (step_notes.size() >= m3ua_pkg::MAX_RESULTS) return;
    n.kind = 4'(k); n.asp = 4'(a); n.tag = 16'(t); n.st = p_as;
    n.avail = 1'(av); n.last = 1'b0;
    step_notes.push_back(n);
  endfunction

  function automatic bit other_up(input int self, input bit want_active);
    for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++) begin
      if (i == self) continue;
      if (want_active ? (p_asp[i] == m3ua_pkg::ST_ACTIVE) : (p_asp[i] != m3ua_pkg::ST_DOWN))
        return 1;
    end
    return 0;
  endfunction

  function automatic void move_to(input logic [1:0] nxt);
    logic [1:0] old;
    bit up, dn;
    old = p_as;
    p_as = nxt;
    if (nxt == m3ua_pkg::ST_DOWN) return;
    if (!p_ipa) note(m3ua_pkg::K_NOTIFY_ALL, 0, 0, 0);
    up = (old != m3ua_pkg::ST_ACTIVE) && (nxt == m3ua_pkg::ST_ACTIVE);
    dn = (old == m3ua_pkg::ST_ACTIVE) && (nxt != m3ua_pkg::ST_ACTIVE);
    if ((p_role == m3ua_pkg::ROLE_ASP && p_sccp) || p_role == m3ua_pkg::ROLE_SG)
      if (up || dn) note(m3ua_pkg::K_AVAIL, 0, 0, up);
  endfunction

  function automatic void go_pending();
    move_to(m3ua_pkg::ST_PENDING);
    p_timer = (p_ticks != 16'd0) ? p_ticks : 16'd1;
  endfunction

  function automatic void predict_as(input req_t r);
    step_notes.delete();
    if (r.action <= 3'd2)
      p_asp[r.asp] = (r.action == m3ua_pkg::OP_INACT) ? m3ua_pkg::ST_INACTIVE :
                     (r.action == m3ua_pkg::OP_DOWN) ? m3ua_pkg::ST_DOWN : m3ua_pkg::ST_ACTIVE;
    case (p_as)
      m3ua_pkg::ST_DOWN: begin
        if (r.action == m3ua_pkg::OP_INACT) move_to(m3ua_pkg::ST_INACTIVE);
        else if (r.action == m3ua_pkg::OP_XFER) note(m3ua_pkg::K_DROP, 0, int'(r.tag), 0);
      end
      m3ua_pkg::ST_INACTIVE: begin
        if (r.action == m3ua_pkg::OP_DOWN) begin
          if (!other_up(int'(r.asp), 1'b0)) move_to(m3ua_pkg::ST_DOWN);
        end else if (r.action == m3ua_pkg::OP_ACT) begin
          move_to(m3ua_pkg::ST_ACTIVE);
          if (r.is_sg) note(m3ua_pkg::K_DUNA, int'(r.asp), 0, 0);
        end else if (r.action == m3ua_pkg::OP_INACT) begin
          if (r.ntfy) note(m3ua_pkg::K_NOTIFY_ONE, int'(r.asp), 0, 0);
        end else if (r.action == m3ua_pkg::OP_XFER) note(m3ua_pkg::K_DROP, 0, int'(r.tag), 0);
      end
      m3ua_pkg::ST_ACTIVE: begin
        if (r.action == m3ua_pkg::OP_DOWN) begin
          if (!other_up(int'(r.asp), 1'b1)) go_pending();
        end else if (r.action == m3ua_pkg::OP_INACT) begin
          if (!other_up(int'(r.asp), 1'b1)) go_pending();
          else if (r.ntfy) note(m3ua_pkg::K_NOTIFY_ONE, int'(r.asp), 0, 0);
        end else if (r.action == m3ua_pkg::OP_ACT) begin
          if (p_override)
            for (int i = 0; i < m3ua_pkg::NUM_ASPS; i++)
              if (i != int'(r.asp) && p_asp[i] == m3ua_pkg::ST_ACTIVE) begin
                note(m3ua_pkg::K_DEMOTE, i, 0, 0);
                p_asp[i] = m3ua_pkg::ST_INACTIVE;
              end
        end else if (r.action == m3ua_pkg::OP_XFER) note(m3ua_pkg::K_FORWARD, 0, int'(r.tag), 0);
      end
      default: begin
        if (r.action == m3ua_pkg::OP_ACT) begin
          p_timer = 16'd0;
          move_to(m3ua_pkg::ST_ACTIVE);
          if (r.is_sg) note(m3ua_pkg::K_DUNA, int'(r.asp), 0, 0);
          while (p_pend.size() > 0) note(m3ua_pkg::K_FORWARD, 0, int'(p_pend.pop_front()), 0);
        end else if (r.action == m3ua_pkg::OP_INACT) begin
          if (r.ntfy) note(m3ua_pkg::K_NOTIFY_ONE, int'(r.asp), 0, 0);
        end else if (r.action == m3ua_pkg::OP_XFER) begin
          if (p_pend.size() < m3ua_pkg::QUEUE_DEPTH) begin
            p_pend.push_back(r.tag);
            note(m3ua_pkg::K_QUEUED, 0, int'(r.tag), 0);
          end else note(m3ua_pkg::K_DROP, 0, int'(r.tag), 0);
        end else if (r.action == m3ua_pkg::OP_TICK && p_timer > 16'd0) begin
          p_timer--;
          if (p_timer == 16'd0) begin
            while (p_pend.size() > 0) note(m3ua_pkg::K_DROP, 0, int'(p_pend.pop_front()), 0);
            if (other_up(m3ua_pkg::NUM_ASPS, 1'b0)) move_to(m3ua_pkg::ST_INACTIVE);
            else move_to(m3ua_pkg::ST_DOWN);
          end
        end
      end
    endcase
    if (step_notes.size() > 0) step_notes[step_notes.size()-1].last = 1'b1;
    foreach (step_notes[i]) expected_notes.push_back(step_notes[i]);
  endfunction

  // driver: feeds pending requests, predicts at each transfer
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        predict_as(pending_reqs.pop_front());
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 6);
      end
      if (push && full) begin
        // hold the current item
      end else if (in_gap > 0) begin
        in_gap = in_gap - 1;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_in) begin
        push <= 1'b1;
        in_action <= pending_reqs[0].action;
        in_asp_index <= pending_reqs[0].asp;
        in_asp_is_sg <= pending_reqs[0].is_sg;
        in_notify_requested <= pending_reqs[0].ntfy;
        in_msg_tag <= pending_reqs[0].tag;
      end else push <= 1'b0;
    end
  end

  // monitor: compares each result transfer with the oldest expectation
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        note_t got, exp;
        got = '{out_result_kind, out_asp_index_res, out_msg_tag_res, out_as_state,
                out_available, out_last};
        if (expected_notes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp = expected_notes.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: kind %0d/%0d asp %0d/%0d tag %h/%h st %0d/%0d",
                        " av %b/%b last %b/%b"},
                       exp.kind, got.kind, exp.asp, got.asp, exp.tag, got.tag,
                       exp.st, got.st, exp.avail, got.avail, exp.last, got.last);
          end
        end
        if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 6);
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  task automatic add_req(input int a, input int asp, input int sg, input int nt,
                         input int tg);
    req_t r;
    r.action = 3'(a); r.asp = 4'(asp); r.is_sg = 1'(sg); r.ntfy = 1'(nt); r.tag = 16'(tg);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || push || expected_notes.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 16'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      m3ua_pkg::CFG_OVERRIDE: p_override = 1'(val);
      m3ua_pkg::CFG_RECOVERY: p_ticks = 16'(val);
      m3ua_pkg::CFG_ROLE:     p_role = 2'(val);
      m3ua_pkg::CFG_IPA:      p_ipa = 1'(val);
      m3ua_pkg::CFG_SCCP:     p_sccp = 1'(val);
      default: ;
    endcase
  endtask

  // well-formed scenario: activate, fall to pending, queue, then recover or expire
  task automatic scenario(input int ticks);
    int n;
    add_req(m3ua_pkg::OP_INACT, $urandom_range(0, 15), $urandom, $urandom, $urandom);
    repeat ($urandom_range(1, 3))
      add_req(m3ua_pkg::OP_ACT, $urandom_range(0, 15), $urandom, 0, 0);
    repeat ($urandom_range(0, 3)) add_req(m3ua_pkg::OP_XFER, $urandom, 0, 0, $urandom);
    add_req(m3ua_pkg::OP_INACT, $urandom_range(0, 15), 0, $urandom, 0);
    add_req(m3ua_pkg::OP_DOWN, $urandom_range(0, 15), 0, 0, 0);
    n = $urandom_range(0, 18);
    repeat (n) add_req(m3ua_pkg::OP_XFER, $urandom, $urandom, 0, $urandom);
    if ($urandom_range(0, 1)) add_req(m3ua_pkg::OP_ACT, $urandom_range(0, 15), $urandom, 0, 0);
    else repeat (ticks) add_req(m3ua_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 3))
      add_req($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int tk;
    p_override = 1'b1; p_ticks = 16'd2000; p_role = 2'd0; p_ipa = 1'b0; p_sccp = 1'b1;
    p_as = m3ua_pkg::ST_DOWN; p_timer = 16'd0;
    foreach (p_asp[i]) p_asp[i] = m3ua_pkg::ST_DOWN;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_reg(m3ua_pkg::CFG_RECOVERY, 2);
    // directed: extremes, every action, down/inactive/active/pending cases
    add_req(m3ua_pkg::OP_XFER, 0, 0, 0, 16'hffff);
    add_req(m3ua_pkg::OP_TICK, 15, 1, 1, 0);
    add_req(m3ua_pkg::OP_INACT, 15, 1, 1, 16'hffff);
    add_req(m3ua_pkg::OP_INACT, 0, 0, 1, 0);
    add_req(m3ua_pkg::OP_XFER, 0, 0, 0, 16'h1234);
    add_req(m3ua_pkg::OP_ACT, 15, 1, 0, 0);
    add_req(m3ua_pkg::OP_ACT, 3, 0, 0, 0);
    add_req(m3ua_pkg::OP_XFER, 0, 0, 0, 16'h0001);
    add_req(m3ua_pkg::OP_INACT, 0, 0, 1, 0);
    add_req(m3ua_pkg::OP_DOWN, 3, 0, 0, 0);
    for (int i = 0; i < 17; i++) add_req(m3ua_pkg::OP_XFER, 0, 0, 0, i * 3855);
    add_req(m3ua_pkg::OP_TICK, 0, 0, 0, 0);
    add_req(m3ua_pkg::OP_TICK, 0, 0, 0, 0);
    add_req(5, 1, 1, 1, 1);
    add_req(7, 2, 0, 0, 2);
    wait_drained();
    // pressure: all activations drained, then several settings
    for (int ph = 0; ph < 6; ph++) begin
      hold_in = 1;
      set_reg(m3ua_pkg::CFG_OVERRIDE, ph % 2);
      tk = (ph == 0) ? 0 : (ph == 5) ? 65535 : $urandom_range(1, 4);
      set_reg(m3ua_pkg::CFG_RECOVERY, tk);
      set_reg(m3ua_pkg::CFG_ROLE, ph % 3);
      set_reg(m3ua_pkg::CFG_IPA, (ph / 2) % 2);
      set_reg(m3ua_pkg::CFG_SCCP, (ph == 3) ? 0 : 1);
      hold_in = 0;
      if (ph == 5) quiet = 1;
      for (int s = 0; s < 2; s++) begin
        if (ph == 5) scenario(2);
        else scenario((tk == 0) ? 1 : tk);
        repeat (6) add_req($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
      end
      wait_drained();
    end
    if (mismatches == 0 && expected_notes.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
